/* rtl/core/sv39pti_pkg.sv */
package sv39pti_pkg;

  // Field widths of the mapping request, the result and the base register.
  localparam int unsigned VPN_W   = 27;
  localparam int unsigned PPN_W   = 44;
  localparam int unsigned LEVEL_W = 9;
  localparam int unsigned ADDED_W = 2;

  // Default number of table pages in the store, the root included.
  localparam int unsigned TABLE_PAGES_DEF = 64;

  // Result status codes.
  localparam logic STATUS_MAPPED   = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

endpackage

/* rtl/core/sv39pti_map_if.sv */
interface sv39pti_map_if;
  logic                           valid;
  logic                           ready;
  logic [sv39pti_pkg::VPN_W-1:0]  virt_page_number;
  logic [sv39pti_pkg::PPN_W-1:0]  phys_page_number;

  modport source (output valid, output virt_page_number, output phys_page_number,
                  input ready);
  modport sink (input valid, input virt_page_number, input phys_page_number,
                output ready);
endinterface

/* rtl/core/sv39pti_result_if.sv */
interface sv39pti_result_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [sv39pti_pkg::ADDED_W-1:0] tables_added;

  modport source (output valid, output status, output tables_added, input ready);
  modport sink (input valid, input status, input tables_added, output ready);
endinterface

/* rtl/core/sv39pti_cfg_if.sv */
interface sv39pti_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sv39pti_pkg::PPN_W-1:0] table_base_ppn;

  modport source (output valid, output table_base_ppn, input ready);
  modport sink (input valid, input table_base_ppn, output ready);
endinterface

/* rtl/core/sv39pti_table_mem.sv */
// Table page store: one write port and one read port, read data registered.
module sv39pti_table_mem #(
  parameter int unsigned DEPTH  = sv39pti_pkg::TABLE_PAGES_DEF * 512,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [sv39pti_pkg::PPN_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [sv39pti_pkg::PPN_W-1:0] rd_data
);

  logic [sv39pti_pkg::PPN_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/sv39_page_table_insert.sv */
// Sv39 page table insert. Each beat on req carries one mapping, a 27-bit
// virtual page number and a 44-bit physical page number, and produces exactly
// one beat on rsp. The three-level table lives in an internal store of
// TABLE_PAGES table pages of 512 entries, with one write and one read port;
// page k answers to physical page number table_base_ppn + k and page 0 is the
// root. Entries hold a plain page number with no valid bit, so zero means "no
// table". Missing level-1 and level-0 tables are handed out in order from a
// free-page counter; if too few pages remain the block writes nothing and
// returns status 1 with tables_added 0. After reset the store is swept to
// zero, one entry per cycle, during which req is not ready (cfg writes are
// taken at any time). Afterwards a mapping reads the root entry and, if that
// names a table page, the level-1 entry, each through the store's registered
// read port; then it checks for space and, unless the store is out of space,
// writes the up to three entries root first, one per cycle, through the
// single write port. The result sits in an output register, so the next
// mapping is accepted while the previous result waits on rsp.
module sv39_page_table_insert #(
  parameter int unsigned TABLE_PAGES = sv39pti_pkg::TABLE_PAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  sv39pti_cfg_if.sink             cfg,
  sv39pti_map_if.sink             req,
  sv39pti_result_if.source        rsp
);

  localparam int unsigned PAGE_W = $clog2(TABLE_PAGES);
  localparam int unsigned ADDR_W = PAGE_W + sv39pti_pkg::LEVEL_W;
  localparam int unsigned DEPTH  = TABLE_PAGES * 512;
  localparam int unsigned CNT_W  = $clog2(TABLE_PAGES + 1);
  localparam int unsigned LW     = sv39pti_pkg::LEVEL_W;
  localparam int unsigned PW     = sv39pti_pkg::PPN_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK_ROOT,
    S_RD_MID,
    S_CHK_MID,
    S_DECIDE,
    S_WR_ROOT,
    S_WR_MID,
    S_WR_LEAF,
    S_DONE
  } state_t;

  state_t                                state;
  logic [ADDR_W-1:0]                     clr_addr;
  logic [PW-1:0]                         table_base_ppn;
  logic [CNT_W-1:0]                      next_free_page;
  logic [sv39pti_pkg::VPN_W-1:0]         vpn;
  logic [PW-1:0]                         leaf_ppn;
  logic [PAGE_W-1:0]                     page1;
  logic [PAGE_W-1:0]                     page0;
  logic [sv39pti_pkg::ADDED_W-1:0]       need;
  logic                                  res_status;

  logic [LW-1:0]                         idx2;
  logic [LW-1:0]                         idx1;
  logic [LW-1:0]                         idx0;

  logic                                  wr_en;
  logic [ADDR_W-1:0]                     wr_addr;
  logic [PW-1:0]                         wr_data;
  logic [ADDR_W-1:0]                     rd_addr;
  logic [PW-1:0]                         rd_data;

  logic [PW-1:0]                         ptr_offset;
  logic                                  ptr_hit;
  logic [CNT_W:0]                        pages_after;
  logic                                  no_space;

  // Level indexes of the request being worked on.
  assign idx2 = vpn[2*LW +: LW];
  assign idx1 = vpn[LW +: LW];
  assign idx0 = vpn[0 +: LW];

  sv39pti_table_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A stored pointer names one of our table pages only if it is nonzero and
  // its distance from the base, taken modulo 2^44, falls inside the store.
  // Anything else is treated as an absent table and gets overwritten.
  assign ptr_offset = rd_data - table_base_ppn;
  assign ptr_hit    = (rd_data != '0) && (ptr_offset < PW'(TABLE_PAGES));

  // Space check for the tables this mapping still needs.
  assign pages_after = {1'b0, next_free_page} + (CNT_W + 1)'(need);
  assign no_space    = (need != '0) && (pages_after > (CNT_W + 1)'(TABLE_PAGES));

  // Read address: the root entry is looked up from the request payload while
  // idle, so its data is ready in the first cycle after the beat. The level-1
  // entry is looked up once the root pointer has been resolved.
  always_comb begin
    unique case (state)
      S_RD_MID: rd_addr = {page1, idx1};
      default:  rd_addr = {PAGE_W'(0), req.virt_page_number[2*LW +: LW]};
    endcase
  end

  // Single write port: the clearing sweep after reset, then the up to three
  // entry writes of a mapping, root first, so each pointer goes in before
  // the table it names is used.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_WR_ROOT: begin
        wr_en   = 1'b1;
        wr_addr = {PAGE_W'(0), idx2};
        wr_data = table_base_ppn + PW'(page1);
      end
      S_WR_MID: begin
        wr_en   = 1'b1;
        wr_addr = {page1, idx1};
        wr_data = table_base_ppn + PW'(page0);
      end
      S_WR_LEAF: begin
        wr_en   = 1'b1;
        wr_addr = {page0, idx0};
        wr_data = leaf_ppn;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      table_base_ppn <= '0;
      next_free_page <= CNT_W'(1);
      rsp.valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        table_base_ppn <= cfg.table_base_ppn;
      end
      // In S_DONE the output register is reloaded below instead.
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            vpn      <= req.virt_page_number;
            leaf_ppn <= req.phys_page_number;
            state    <= S_CHK_ROOT;
          end
        end
        S_CHK_ROOT: begin
          page1 <= ptr_offset[PAGE_W-1:0];
          if (ptr_hit) begin
            state <= S_RD_MID;
          end else begin
            need  <= sv39pti_pkg::ADDED_W'(2);
            state <= S_DECIDE;
          end
        end
        S_RD_MID: begin
          state <= S_CHK_MID;
        end
        S_CHK_MID: begin
          page0 <= ptr_offset[PAGE_W-1:0];
          need  <= ptr_hit ? sv39pti_pkg::ADDED_W'(0) : sv39pti_pkg::ADDED_W'(1);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (no_space) begin
            res_status <= sv39pti_pkg::STATUS_NO_SPACE;
            state      <= S_DONE;
          end else begin
            res_status     <= sv39pti_pkg::STATUS_MAPPED;
            next_free_page <= pages_after[CNT_W-1:0];
            priority case (need)
              sv39pti_pkg::ADDED_W'(2): begin
                page1 <= next_free_page[PAGE_W-1:0];
                page0 <= next_free_page[PAGE_W-1:0] + PAGE_W'(1);
                state <= S_WR_ROOT;
              end
              sv39pti_pkg::ADDED_W'(1): begin
                page0 <= next_free_page[PAGE_W-1:0];
                state <= S_WR_MID;
              end
              default: begin
                state <= S_WR_LEAF;
              end
            endcase
          end
        end
        S_WR_ROOT: begin
          state <= S_WR_MID;
        end
        S_WR_MID: begin
          state <= S_WR_LEAF;
        end
        S_WR_LEAF: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // Hand the result to the output register once it is free.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.tables_added <= (res_status == sv39pti_pkg::STATUS_NO_SPACE) ?
                                '0 : need;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The free-page counter always covers the root and never runs past the store.
  assert property (@(posedge clk) disable iff (rst)
    (next_free_page >= CNT_W'(1)) && (next_free_page <= CNT_W'(TABLE_PAGES)))
    else $error("free-page counter out of range");

  // A mapping refused for lack of space takes no pages.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && no_space) |=> (next_free_page == $past(next_free_page)))
    else $error("out-of-space mapping changed the free-page counter");

  // No store write overlaps the acceptance of a new mapping.
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !wr_en)
    else $error("store write while a mapping beat is accepted");

  // A refused mapping never reports added tables.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == sv39pti_pkg::STATUS_NO_SPACE) |-> (rsp.tables_added == '0))
    else $error("out-of-space result reports added tables");

endmodule

/* test/tb_top.sv */
// Shadow copy of the Sv39 table store. It predicts the outcome of every
// accepted mapping and checks each returned result against it in order.
class sv39_table_shadow;
  localparam int unsigned PAGES   = sv39pti_pkg::TABLE_PAGES_DEF;
  localparam int unsigned ENTRIES = 512;

  typedef struct packed {
    logic       status;
    logic [1:0] tables_added;
  } outcome_t;

  bit [sv39pti_pkg::PPN_W-1:0] entries_mem [PAGES*ENTRIES];
  bit [sv39pti_pkg::PPN_W-1:0] base_ppn;
  int unsigned                 pages_used;
  outcome_t                    outcomes_due[$];

  int unsigned error_count;
  int unsigned refused_count;
  int unsigned base_writes;
  int unsigned added_count[3];

  function new();
    base_ppn   = '0;
    pages_used = 1;
  endfunction

  function void set_base(bit [sv39pti_pkg::PPN_W-1:0] ppn);
    base_ppn = ppn;
    base_writes++;
  endfunction

  // Table page an entry points at, or -1 when the entry counts as absent.
  function int table_page(bit [sv39pti_pkg::PPN_W-1:0] entry);
    bit [sv39pti_pkg::PPN_W-1:0] offset;
    if (entry == '0) return -1;
    offset = entry - base_ppn;
    if (offset >= PAGES) return -1;
    return int'(offset);
  endfunction

  function void note_mapping(bit [sv39pti_pkg::VPN_W-1:0] vpn,
                             bit [sv39pti_pkg::PPN_W-1:0] leaf_ppn);
    int          root_ix;
    int          mid_ix;
    int          leaf_ix;
    int          mid_page;
    int          leaf_page;
    int unsigned needed;
    outcome_t    outcome;
    root_ix   = int'(vpn[26:18]);
    mid_ix    = int'(vpn[17:9]);
    leaf_ix   = int'(vpn[8:0]);
    leaf_page = -1;
    mid_page  = table_page(entries_mem[root_ix]);
    if (mid_page < 0) begin
      needed = 2;
    end else begin
      leaf_page = table_page(entries_mem[mid_page*ENTRIES + mid_ix]);
      needed = (leaf_page < 0) ? 1 : 0;
    end
    if (needed > 0 && pages_used + needed > PAGES) begin
      outcome.status       = sv39pti_pkg::STATUS_NO_SPACE;
      outcome.tables_added = '0;
      outcomes_due.push_back(outcome);
      return;
    end
    if (mid_page < 0) begin
      mid_page = int'(pages_used);
      pages_used++;
      entries_mem[root_ix] = base_ppn + sv39pti_pkg::PPN_W'(mid_page);
    end
    if (leaf_page < 0) begin
      leaf_page = int'(pages_used);
      pages_used++;
      entries_mem[mid_page*ENTRIES + mid_ix] = base_ppn + sv39pti_pkg::PPN_W'(leaf_page);
    end
    entries_mem[leaf_page*ENTRIES + leaf_ix] = leaf_ppn;
    outcome.status       = sv39pti_pkg::STATUS_MAPPED;
    outcome.tables_added = 2'(needed);
    outcomes_due.push_back(outcome);
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task check_outcome(logic status, logic [1:0] tables_added);
    outcome_t want;
    if (outcomes_due.size() == 0) begin
      report_mismatch($sformatf("result status=%0b tables_added=%0d with nothing pending",
                                status, tables_added));
      return;
    end
    want = outcomes_due.pop_front();
    if (status !== want.status)
      report_mismatch($sformatf("status %0b, expected %0b", status, want.status));
    if (tables_added !== want.tables_added)
      report_mismatch($sformatf("tables_added %0d, expected %0d",
                                tables_added, want.tables_added));
    if (want.status == sv39pti_pkg::STATUS_NO_SPACE) refused_count++;
    else added_count[want.tables_added]++;
  endtask

  task audit_leftovers();
    if (outcomes_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
  endtask
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // After reset the block sweeps its whole store to zero, one entry per
  // cycle, and holds req low on ready meanwhile. The stall limit allows
  // for that sweep several times over, on top of the longest gaps and
  // receiver stalls that the stimulus below can produce.
  localparam int unsigned SWEEP_CYCLES  = sv39pti_pkg::TABLE_PAGES_DEF * 512;
  localparam int unsigned STALL_LIMIT   = 4 * SWEEP_CYCLES + 4096;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned VPN_W         = sv39pti_pkg::VPN_W;
  localparam int unsigned PPN_W         = sv39pti_pkg::PPN_W;
  localparam logic [PPN_W-1:0] PPN_ALL_ONES = '1;

  // Receiver stall patterns. Each one holds for a random stretch of cycles.
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

  logic clk;
  logic rst;

  sv39pti_cfg_if    cfg();
  sv39pti_map_if    req();
  sv39pti_result_if rsp();

  sv39_page_table_insert #(
    .TABLE_PAGES(sv39pti_pkg::TABLE_PAGES_DEF)
  ) uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  sv39_table_shadow shadow = new();

  logic [VPN_W-1:0] recent_vpns[$];
  int unsigned      stall_cycles = 0;
  rx_mode_t         rx_mode      = RX_ALWAYS;
  int unsigned      rx_left      = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Every beat on any channel is observed here at the clock edge, before
  // the nonblocking updates of that edge land. An accepted mapping feeds the
  // shadow table, a result beat is checked against the oldest prediction,
  // and a base write updates the shadow's copy of the register. The same
  // block keeps the count of cycles without any beat for the watchdog.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (cfg.valid && cfg.ready) shadow.set_base(cfg.table_base_ppn);
      if (req.valid && req.ready)
        shadow.note_mapping(req.virt_page_number, req.phys_page_number);
      if (rsp.valid && rsp.ready) shadow.check_outcome(rsp.status, rsp.tables_added);
      if ((cfg.valid && cfg.ready) || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // The result side switches among always ready, coin-flip stalls, mostly
  // stalled, and long regular stalls, so that back-pressure lands on every
  // stage of a mapping, including while the next one is already inside the
  // block.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: rsp.ready <= 1'b1;
      RX_COIN:   rsp.ready <= ($urandom_range(0, 1) == 0);
      RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
      default:   rsp.ready <= (rx_left[2:0] == 3'd0);
    endcase
  end

  // The run ends in failure if the block goes quiet for too long.
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [PPN_W-1:0] random_ppn();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[PPN_W-1:0];
  endfunction

  // Leaf page numbers: mostly random, with the two extremes mixed in.
  function automatic logic [PPN_W-1:0] pick_ppn();
    int unsigned choice;
    choice = $urandom_range(0, 15);
    if (choice == 0) return '0;
    if (choice == 1) return PPN_ALL_ONES;
    return random_ppn();
  endfunction

  // Fully random virtual page numbers would almost always need a new root
  // entry and use up the table pages within a few dozen beats. Most picks
  // therefore reuse the upper indexes of a recent mapping, so that the
  // existing-table paths, the one-new-table path and leaf overwrites stay
  // busy long after the store is full.
  function automatic logic [VPN_W-1:0] pick_vpn();
    int unsigned      choice;
    logic [VPN_W-1:0] vpn;
    choice = $urandom_range(0, 9);
    if (recent_vpns.size() == 0 || choice >= 8) return VPN_W'($urandom);
    vpn = recent_vpns[$urandom_range(0, recent_vpns.size() - 1)];
    if (choice < 5) vpn[8:0] = 9'($urandom);        // same leaf table
    else if (choice < 7) vpn[17:0] = 18'($urandom); // same level-1 table
    return vpn;                                      // exact repeat overwrites
  endfunction

  // Presents one mapping and returns at the edge where it is taken. The
  // valid line is left high, so a caller that sends again right away keeps
  // the beats back to back.
  task automatic send_mapping(logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] ppn);
    req.valid            <= 1'b1;
    req.virt_page_number <= vpn;
    req.phys_page_number <= ppn;
    recent_vpns.push_back(vpn);
    if (recent_vpns.size() > 32) void'(recent_vpns.pop_front());
    do @(posedge clk); while (req.ready !== 1'b1);
  endtask

  // Drops valid and waits until every predicted result has come back, then
  // keeps waiting so that the block has certainly gone idle. The queue is
  // checked only after clock edges, so the monitor has seen the last beat.
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (shadow.outcomes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(logic [PPN_W-1:0] ppn);
    cfg.valid          <= 1'b1;
    cfg.table_base_ppn <= ppn;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    cfg.valid <= 1'b0;
  endtask

  // Random mappings sent in bursts of random length. About one burst in four
  // follows the previous one with no gap at all, and every hundred beats the
  // sender stops until all results are back.
  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned gap;
    sent = 0;
    while (sent < count) begin
      repeat ($urandom_range(1, 16)) begin
        if (sent < count) begin
          send_mapping(pick_vpn(), pick_ppn());
          sent++;
          if (sent % 100 == 0) drain();
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [PPN_W-1:0] zero_base;
    rst                  <= 1'b1;
    cfg.valid            <= 1'b0;
    cfg.table_base_ppn   <= '0;
    req.valid            <= 1'b0;
    req.virt_page_number <= '0;
    req.phys_page_number <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Base zero: two fresh roots at both ends of the index range, a leaf
    // overwrite with the extreme page numbers, a path through existing
    // tables, a path needing only a new leaf table, and alternating bits.
    write_base('0);
    send_mapping('0, '0);
    send_mapping('0, PPN_ALL_ONES);
    send_mapping('1, random_ppn());
    send_mapping({9'h1ff, 9'h1ff, 9'h000}, random_ppn());
    send_mapping({9'h000, 9'h1ff, 9'h1ff}, random_ppn());
    send_mapping({9'h155, 9'h0aa, 9'h155}, 44'haaa_aaaa_aaaa);
    send_mapping({9'h0aa, 9'h155, 9'h0aa}, 44'h555_5555_5555);
    drain();

    // Base all ones: the stored pointers now resolve one page further on,
    // so the old tables alias each other, and others read as stray.
    write_base(PPN_ALL_ONES);
    send_mapping('0, random_ppn());
    send_mapping('1, random_ppn());
    send_mapping({9'h0aa, 9'h155, 9'h1aa}, random_ppn());
    drain();

    // Place the base so that the next table page handed out has physical
    // page number zero. Its pointer then reads back as absent, and a second
    // mapping under the same root entry takes two fresh pages again.
    zero_base = '0 - PPN_W'(shadow.pages_used);
    write_base(zero_base);
    send_mapping({9'h0f0, 9'h001, 9'h002}, random_ppn());
    send_mapping({9'h0f0, 9'h003, 9'h004}, random_ppn());
    drain();

    // A random base makes every pointer written so far a stray one, which
    // must be replaced by a new table and overwritten.
    write_base(random_ppn());
    send_mapping('0, random_ppn());
    send_mapping({9'h1ff, 9'h1ff, 9'h001}, random_ppn());
    send_mapping({9'h123, 9'h045, 9'h067}, random_ppn());
    drain();

    // Back to base zero, where the early tables are valid once more, for
    // most of the random traffic; the rest runs under the all-ones base.
    write_base('0);
    run_random(RANDOM_ITEMS * 3 / 4);
    drain();
    write_base(PPN_ALL_ONES);
    run_random(RANDOM_ITEMS / 4);
    drain();

    shadow.audit_leftovers();
    $display("Mappings checked: %0d through existing tables, %0d with one new table,",
             shadow.added_count[0], shadow.added_count[1]);
    $display("%0d with two, %0d refused for lack of pages; base written %0d times.",
             shadow.added_count[2], shadow.refused_count, shadow.base_writes);
    if (shadow.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
